[hw/rtl/dpb_pkg.sv]
// Shared types, constants and arithmetic helpers for the depth pixel back-projection block.
package dpb_pkg;

  // Item codes carried in the op field.
  localparam logic OP_POSE  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INV_FOCAL_X     = 3'd0;
  localparam logic [2:0] CFG_INV_FOCAL_Y     = 3'd1;
  localparam logic [2:0] CFG_CENTER_X        = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y        = 3'd3;
  localparam logic [2:0] CFG_INV_DEPTH_SCALE = 3'd4;
  localparam logic [2:0] CFG_FAR_DEPTH       = 3'd5;
  localparam logic [2:0] CFG_MIN_DEPTH       = 3'd6;
  localparam logic [2:0] CFG_EDGE_MARGIN     = 3'd7;

  // Configuration reset values.
  localparam logic [31:0] RST_INV_FOCAL_X     = 32'd12386708;
  localparam logic [31:0] RST_INV_FOCAL_Y     = 32'd12301914;
  localparam logic [25:0] RST_CENTER_X        = 26'd21157642;
  localparam logic [25:0] RST_CENTER_Y        = 26'd15371469;
  localparam logic [31:0] RST_INV_DEPTH_SCALE = 32'd4294967;
  localparam logic [30:0] RST_FAR_DEPTH       = 31'd688128;
  localparam logic [30:0] RST_MIN_DEPTH       = 31'd13107;
  localparam logic [5:0]  RST_EDGE_MARGIN     = 6'd2;

  // Pose word layout: rotation row-major first, then translation x, y, z.
  localparam logic [3:0] POSE_TRANS_BASE = 4'd9;
  localparam logic [3:0] POSE_WORDS      = 4'd12;

  // Width used for the image border and grid arithmetic (sizes up to 8191).
  localparam int unsigned GRID_W = 13;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] inv_focal_x;
    logic [31:0] inv_focal_y;
    logic [25:0] center_x;
    logic [25:0] center_y;
    logic [31:0] inv_depth_scale;
    logic [30:0] far_depth;
    logic [30:0] min_depth;
    logic [5:0]  edge_margin;
  } cfg_t;

  // Camera-frame point, or a pose word passing through in order.
  typedef struct packed {
    logic               op;
    logic [3:0]         pose_index;
    logic signed [31:0] pose_value;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cam_point_t;

  // Arithmetic right shift that rounds half away from zero.
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< (s - 1)) - ((v < 0) ? 64'sd1 : 64'sd0);
    return (v + bias) >>> s;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/dpb_if.sv]
// Handshake channels for depth pixels in and world points out.
interface dpb_pixel_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [3:0]         pose_index;
  logic signed [31:0] pose_value;
  logic [8:0]         pixel_row;
  logic [9:0]         pixel_col;
  logic [15:0]        raw_depth;

  modport source (output valid, op, pose_index, pose_value, pixel_row, pixel_col, raw_depth,
                  input ready);
  modport sink (input valid, op, pose_index, pose_value, pixel_row, pixel_col, raw_depth,
                output ready);
endinterface

interface dpb_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

[hw/rtl/dpb_camera.sv]
// Five-stage pipeline from a depth pixel to a camera-frame point.
module dpb_camera
  import dpb_pkg::*;
#(
  parameter int IMAGE_ROWS  = 480,
  parameter int IMAGE_COLS  = 640,
  parameter int SAMPLE_STEP = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  dpb_pixel_if.sink        pixel,
  output logic             cam_valid,
  input  logic             cam_ready,
  output cam_point_t       cam_point
);

  // Remainder by the step is taken through a multiply by a rounded-up reciprocal.
  localparam int unsigned StepK     = 18;
  localparam int unsigned StepRecip = ((1 << StepK) + SAMPLE_STEP - 1) / SAMPLE_STEP;

  function automatic logic on_grid(input logic [GRID_W-1:0] pos,
                                   input logic [GRID_W-1:0] size,
                                   input logic [GRID_W-1:0] margin);
    logic [GRID_W-1:0] off;
    logic [31:0]       prod;
    logic [31:0]       quot;
    logic              ok;
    off  = pos - margin;
    prod = 32'(off) * 32'(StepRecip);
    quot = prod >> StepK;
    ok   = (pos >= margin) && ((pos + margin) < size) &&
           ((quot * 32'(SAMPLE_STEP)) == 32'(off));
    return ok;
  endfunction

  logic adv1, adv2, adv3, adv4, adv5;
  logic grid_ok, near;
  logic [47:0] zround;
  logic [31:0] zu_calc;
  logic signed [63:0] ax_r, ay_r, px_r, py_r;

  logic               s1_valid, s1_op, s1_raw_zero;
  logic [3:0]         s1_index;
  logic signed [31:0] s1_value;
  logic [47:0]        s1_zprod;
  logic signed [26:0] s1_dx, s1_dy;

  logic               s2_valid, s2_op;
  logic [3:0]         s2_index;
  logic signed [31:0] s2_value;
  logic [31:0]        s2_zu;
  logic signed [59:0] s2_axp, s2_ayp;

  logic               s3_valid, s3_op;
  logic [3:0]         s3_index;
  logic signed [31:0] s3_value;
  logic [31:0]        s3_zu;
  logic signed [27:0] s3_ax, s3_ay;

  logic               s4_valid, s4_op;
  logic [3:0]         s4_index;
  logic signed [31:0] s4_value;
  logic [31:0]        s4_zu;
  logic signed [60:0] s4_pxp, s4_pyp;

  logic               s5_valid;

  assign adv5 = !s5_valid || cam_ready;
  assign adv4 = !s4_valid || adv5;
  assign adv3 = !s3_valid || adv4;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign pixel.ready = adv1;
  assign cam_valid   = s5_valid;

  assign grid_ok = on_grid(GRID_W'(pixel.pixel_row), GRID_W'(IMAGE_ROWS),
                           GRID_W'(cfg.edge_margin)) &&
                   on_grid(GRID_W'(pixel.pixel_col), GRID_W'(IMAGE_COLS),
                           GRID_W'(cfg.edge_margin));

  assign zround  = s1_zprod + 48'h8000;
  assign zu_calc = s1_raw_zero ? {1'b0, cfg.far_depth} : zround[47:16];
  assign near    = s2_zu < {1'b0, cfg.min_depth};

  assign ax_r = shr_round(64'(s2_axp), 32);
  assign ay_r = shr_round(64'(s2_ayp), 32);
  assign px_r = shr_round(64'(s4_pxp), 16);
  assign py_r = shr_round(64'(s4_pyp), 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      // Off-grid pixels vanish at entry; pose words always travel on.
      if (adv1) s1_valid <= pixel.valid && (pixel.op == OP_POSE || grid_ok);
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid && (s2_op == OP_POSE || !near);
      if (adv4) s4_valid <= s3_valid;
      if (adv5) s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_op       <= pixel.op;
      s1_index    <= pixel.pose_index;
      s1_value    <= pixel.pose_value;
      s1_raw_zero <= (pixel.raw_depth == 16'd0);
      s1_zprod    <= 48'(pixel.raw_depth) * 48'(cfg.inv_depth_scale);
      s1_dx       <= $signed({1'b0, pixel.pixel_col, 16'b0}) - $signed({1'b0, cfg.center_x});
      s1_dy       <= $signed({2'b0, pixel.pixel_row, 16'b0}) - $signed({1'b0, cfg.center_y});
    end
    if (adv2) begin
      s2_op    <= s1_op;
      s2_index <= s1_index;
      s2_value <= s1_value;
      s2_zu    <= zu_calc;
      s2_axp   <= s1_dx * $signed({1'b0, cfg.inv_focal_x});
      s2_ayp   <= s1_dy * $signed({1'b0, cfg.inv_focal_y});
    end
    if (adv3) begin
      s3_op    <= s2_op;
      s3_index <= s2_index;
      s3_value <= s2_value;
      s3_zu    <= s2_zu;
      s3_ax    <= ax_r[27:0];
      s3_ay    <= ay_r[27:0];
    end
    if (adv4) begin
      s4_op    <= s3_op;
      s4_index <= s3_index;
      s4_value <= s3_value;
      s4_zu    <= s3_zu;
      s4_pxp   <= s3_ax * $signed({1'b0, s3_zu});
      s4_pyp   <= s3_ay * $signed({1'b0, s3_zu});
    end
    if (adv5) begin
      cam_point.op         <= s4_op;
      cam_point.pose_index <= s4_index;
      cam_point.pose_value <= s4_value;
      cam_point.x          <= sat32(px_r);
      cam_point.y          <= sat32(py_r);
      cam_point.z          <= s4_zu[31] ? 32'sh7FFFFFFF : $signed(s4_zu);
    end
  end

endmodule

[hw/rtl/dpb_xform.sv]
// Pose storage and three-stage rotate-and-translate pipeline to world points.
module dpb_xform
  import dpb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cam_valid,
  output logic             cam_ready,
  input  cam_point_t       cam_point,
  dpb_point_if.source      point
);

  logic adv_a, adv_b, adv_c;
  logic pose_write;
  logic [1:0] trans_idx;
  logic signed [31:0] cvec [3];
  logic signed [63:0] rterm [9];
  logic signed [35:0] acc [3];

  logic signed [31:0] rot [9];
  logic signed [31:0] trans [3];

  logic               a_valid;
  logic signed [63:0] a_prod [9];
  logic signed [31:0] a_trans [3];

  logic               b_valid;
  logic signed [33:0] b_term [9];
  logic signed [31:0] b_trans [3];

  logic               c_valid;
  logic signed [31:0] c_world [3];

  assign adv_c     = !c_valid || point.ready;
  assign adv_b     = !b_valid || adv_c;
  assign adv_a     = !a_valid || adv_b;
  assign cam_ready = adv_a;

  assign point.valid   = c_valid;
  assign point.world_x = c_world[0];
  assign point.world_y = c_world[1];
  assign point.world_z = c_world[2];

  assign cvec[0] = cam_point.x;
  assign cvec[1] = cam_point.y;
  assign cvec[2] = cam_point.z;

  // Pose words land at the same point where pixels read the pose, so order holds.
  assign pose_write = cam_valid && adv_a && (cam_point.op == OP_POSE);
  assign trans_idx  = 2'(cam_point.pose_index - POSE_TRANS_BASE);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rterm[i] = shr_round(a_prod[i], 30);
    end
    for (int k = 0; k < 3; k++) begin
      acc[k] = 36'(b_trans[k]) + 36'(b_term[3*k]) + 36'(b_term[3*k+1]) +
               36'(b_term[3*k+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) rot[i] <= '0;
      for (int k = 0; k < 3; k++) trans[k] <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (pose_write) begin
        if (cam_point.pose_index < POSE_TRANS_BASE) begin
          rot[cam_point.pose_index] <= cam_point.pose_value;
        end else if (cam_point.pose_index < POSE_WORDS) begin
          trans[trans_idx] <= cam_point.pose_value;
        end
      end
      if (adv_a) a_valid <= cam_valid && (cam_point.op == OP_PIXEL);
      if (adv_b) b_valid <= a_valid;
      if (adv_c) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          a_prod[3*k+j] <= rot[3*k+j] * cvec[j];
        end
        a_trans[k] <= trans[k];
      end
    end
    if (adv_b) begin
      for (int i = 0; i < 9; i++) b_term[i] <= rterm[i][33:0];
      for (int k = 0; k < 3; k++) b_trans[k] <= a_trans[k];
    end
    if (adv_c) begin
      for (int k = 0; k < 3; k++) c_world[k] <= sat32(64'(acc[k]));
    end
  end

endmodule

[hw/rtl/depth_pixel_backprojection.sv]
// Top level of the depth pixel back-projection block: configuration and pipeline assembly.
//
//   Channel   Dir   Handshake         Carries
//   pixel     in    valid / ready     op, pose_index, pose_value, pixel_row, pixel_col,
//                                     raw_depth
//   point     out   valid / ready     world_x, world_y, world_z
//   cfg       in    cfg_wen           cfg_index, cfg_data (no read-back)
//
// One item is taken per cycle while pixel.ready is high. A pixel that yields a point
// passes eight register stages: five that scale the depth and form the camera-frame
// point, then three that rotate, round and translate it before it is offered on the
// point channel.
// Reset is synchronous and active high; it loads the default intrinsics and clears the pose.
// Each stage holds its item only while the stage after it is full and blocked, so bubbles
// close up and a stalled point channel does not stop intake until the pipeline is full.
module depth_pixel_backprojection
  import dpb_pkg::*;
#(
  parameter int IMAGE_ROWS  = 480,
  parameter int IMAGE_COLS  = 640,
  parameter int SAMPLE_STEP = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  dpb_pixel_if.sink   pixel,
  dpb_point_if.source point
);

  // Intrinsics and depth limits. The user changes them only while the block is idle (the
  // block does not enforce it); the pipeline stages read them without a copy per item.
  cfg_t cfg;

  // Camera stage output feeding the pose transform.
  logic       cam_valid;
  logic       cam_ready;
  cam_point_t cam_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_focal_x     <= RST_INV_FOCAL_X;
      cfg.inv_focal_y     <= RST_INV_FOCAL_Y;
      cfg.center_x        <= RST_CENTER_X;
      cfg.center_y        <= RST_CENTER_Y;
      cfg.inv_depth_scale <= RST_INV_DEPTH_SCALE;
      cfg.far_depth       <= RST_FAR_DEPTH;
      cfg.min_depth       <= RST_MIN_DEPTH;
      cfg.edge_margin     <= RST_EDGE_MARGIN;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_INV_FOCAL_X:     cfg.inv_focal_x     <= cfg_data;
        CFG_INV_FOCAL_Y:     cfg.inv_focal_y     <= cfg_data;
        CFG_CENTER_X:        cfg.center_x        <= cfg_data[25:0];
        CFG_CENTER_Y:        cfg.center_y        <= cfg_data[25:0];
        CFG_INV_DEPTH_SCALE: cfg.inv_depth_scale <= cfg_data;
        CFG_FAR_DEPTH:       cfg.far_depth       <= cfg_data[30:0];
        CFG_MIN_DEPTH:       cfg.min_depth       <= cfg_data[30:0];
        CFG_EDGE_MARGIN:     cfg.edge_margin     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Stages one to five: grid test and depth scaling, focal multiplies and the near-depth
  // drop, rounding, depth multiplies, then saturation into a camera-frame point. Pose
  // words ride along unchanged so they stay in order with the pixels around them.
  dpb_camera #(
    .IMAGE_ROWS  (IMAGE_ROWS),
    .IMAGE_COLS  (IMAGE_COLS),
    .SAMPLE_STEP (SAMPLE_STEP)
  ) u_camera (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixel     (pixel),
    .cam_valid (cam_valid),
    .cam_ready (cam_ready),
    .cam_point (cam_point)
  );

  // Stages six to eight: pose words are written into the pose registers here, and pixels
  // go through the nine rotation products, their rounding, and the sum with translation.
  dpb_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .cam_valid (cam_valid),
    .cam_ready (cam_ready),
    .cam_point (cam_point),
    .point     (point)
  );

endmodule
